// File: src/ott_pkg.sv
package ott_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_ADD_ONCE     = 2'd0,
        KIND_ADD_PERIODIC = 2'd1,
        KIND_CANCEL       = 2'd2,
        KIND_TIME         = 2'd3
    } ott_kind_t;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // most fired ids reported for one time request
    localparam int MAX_OUT = 16;
    localparam int NF_W    = $clog2(MAX_OUT + 1);

    typedef struct packed {
        ott_kind_t   kind;
        logic [31:0] delay;
        logic [31:0] cancel_id;
        logic [31:0] now_time;
    } ott_req_t;

    typedef struct packed {
        logic [31:0] timer_id;
        logic        fired;
        logic [1:0]  status;
        logic        last;
    } ott_rsp_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] due;
        logic [31:0] period;
        logic        cancelled;
    } ott_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_RESP,
        ST_C_START,
        ST_C_SCAN,
        ST_T_START,
        ST_T_SCAN,
        ST_T_FLUSH
    } ott_state_t;

endpackage

// File: src/oneshot_periodic_timer_table.sv
// table of software timers, one-shot and periodic, kept in insertion order
//
// request channel (req_valid / req_ready / req_data): add one-shot, add
// periodic, cancel by id, or advance time. a request is taken only while the
// block is idle; the previous result may still be waiting on the result side.
// result channel (rsp_valid / rsp_ready / rsp_data): one result per add or
// cancel; a time request gives one result per fired timer, up to MAX_OUT, in
// table order, with last set on the final one, and no result when nothing fires.
// all entries live in one slot memory with a registered read; cancel and time
// requests walk it one entry per cycle (a time walk holds while the receiver
// stalls), reading, modifying and writing back (a time request compacts the
// table in the same pass). an add writes the next free slot directly; a
// cancel stops at the first match, a time request inspects every used slot.
// an add or cancel result is registered in the same cycle that the block is
// ready again.
// a fired id is held back one entry so that last can be known; if the
// receiver stalls, the walk holds in place and the read is repeated.
// reset: table empty, next id 1, time 0. no clearing pass is needed, only
// entries below the fill count are ever read.
module oneshot_periodic_timer_table
    import ott_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ott_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ott_rsp_t rsp_data
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam int ENT_W = $bits(ott_entry_t);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TIMER_SLOTS);

    // control state
    ott_state_t       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;     // fill count
    logic [CNT_W-1:0] idx_reg, idx_next;       // entry on the read port
    logic [CNT_W-1:0] wr_reg, wr_next;         // compaction write slot
    logic [31:0]      id_ctr_reg, id_ctr_next;
    logic [31:0]      time_reg, time_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [NF_W-1:0]  nfire_reg, nfire_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload holding
    ott_req_t    req_reg, req_next;
    logic [31:0] resp_id_reg, resp_id_next;
    logic [1:0]  resp_status_reg, resp_status_next;
    logic [31:0] pend_id_reg, pend_id_next;
    ott_rsp_t    rsp_data_reg, rsp_data_next;

    // slot memory
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ott_entry_t       ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    ott_entry_t       entry;

    // working values
    logic             out_free;
    logic             emit;
    ott_rsp_t         emit_data;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] wr_inc;
    logic [31:0]      add_period;
    logic             fire;
    logic             report;
    logic             keep;

    ott_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry     = ott_entry_t'(ram_rdata);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign wr_inc    = wr_reg + CNT_W'(1);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // period of a new periodic timer: zero becomes one
    assign add_period = (req_reg.kind != KIND_ADD_PERIODIC) ? 32'd0 :
                        (req_reg.delay == 32'd0) ? 32'd1 : req_reg.delay;

    // due test on the entry currently read, unsigned compare
    assign fire   = !entry.cancelled && (time_reg >= entry.due);
    assign report = fire && (nfire_reg < NF_W'(MAX_OUT));
    assign keep   = !entry.cancelled && (!fire || (entry.period != 32'd0));

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        idx_next         = idx_reg;
        wr_next          = wr_reg;
        id_ctr_next      = id_ctr_reg;
        time_next        = time_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        nfire_next       = nfire_reg;
        req_next         = req_reg;
        resp_id_next     = resp_id_reg;
        resp_status_next = resp_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[IDX_W-1:0];
        ram_wdata        = entry;
        ram_raddr        = idx_reg[IDX_W-1:0];
        emit             = 1'b0;
        emit_data        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_data;
                    idx_next        = '0;
                    wr_next         = '0;
                    nfire_next      = '0;
                    pend_valid_next = 1'b0;
                    case (req_data.kind)
                        KIND_ADD_ONCE, KIND_ADD_PERIODIC:
                        begin
                            state_next = ST_ADD;
                        end
                        KIND_CANCEL:
                        begin
                            state_next = ST_C_START;
                        end
                        default:
                        begin
                            time_next  = req_data.now_time;
                            state_next = ST_T_START;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (used_reg == SLOTS_CNT)
                begin
                    resp_id_next     = 32'd0;
                    resp_status_next = STATUS_FULL;
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = used_reg[IDX_W-1:0];
                    ram_wdata.id        = id_ctr_reg;
                    ram_wdata.period    = add_period;
                    ram_wdata.cancelled = 1'b0;
                    ram_wdata.due       = time_reg +
                        ((req_reg.kind == KIND_ADD_PERIODIC) ? add_period : req_reg.delay);
                    used_next           = used_reg + CNT_W'(1);
                    id_ctr_next         = id_ctr_reg + 32'd1;
                    resp_id_next        = id_ctr_reg;
                    resp_status_next    = STATUS_OK;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    emit_data.timer_id = resp_id_reg;
                    emit_data.fired    = 1'b0;
                    emit_data.status   = resp_status_reg;
                    emit_data.last     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_C_START:
            begin
                resp_id_next = req_reg.cancel_id;
                ram_raddr    = '0;
                if (used_reg == '0)
                begin
                    resp_status_next = STATUS_NOT_FOUND;
                    state_next       = ST_RESP;
                end
                else
                begin
                    state_next = ST_C_SCAN;
                end
            end

            ST_C_SCAN:
            begin
                if (entry.id == req_reg.cancel_id)
                begin
                    // first match only, already cancelled matches again
                    ram_we              = 1'b1;
                    ram_wdata.cancelled = 1'b1;
                    resp_status_next    = STATUS_OK;
                    state_next          = ST_RESP;
                end
                else if (idx_inc == used_reg)
                begin
                    resp_status_next = STATUS_NOT_FOUND;
                    state_next       = ST_RESP;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[IDX_W-1:0];
                end
            end

            ST_T_START:
            begin
                ram_raddr = '0;
                if (used_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_T_SCAN;
                end
            end

            ST_T_SCAN:
            begin
                if (report && pend_valid_reg && !out_free)
                begin
                    // hold the walk, re-read the same entry
                    ram_raddr = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit               = 1'b1;
                            emit_data.timer_id = pend_id_reg;
                            emit_data.fired    = 1'b1;
                            emit_data.status   = STATUS_OK;
                            emit_data.last     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = entry.id;
                        nfire_next      = nfire_reg + NF_W'(1);
                    end
                    if (keep)
                    begin
                        // compaction: write slot never passes the read slot
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg[IDX_W-1:0];
                        if (fire)
                        begin
                            ram_wdata.due = time_reg + entry.period;
                        end
                        wr_next = wr_inc;
                    end
                    if (idx_inc == used_reg)
                    begin
                        used_next  = keep ? wr_inc : wr_reg;
                        state_next = ST_T_FLUSH;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc[IDX_W-1:0];
                    end
                end
            end

            ST_T_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit               = 1'b1;
                    emit_data.timer_id = pend_id_reg;
                    emit_data.fired    = 1'b1;
                    emit_data.status   = STATUS_OK;
                    emit_data.last     = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = emit_data;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            idx_reg        <= '0;
            wr_reg         <= '0;
            id_ctr_reg     <= 32'd1;
            time_reg       <= 32'd0;
            pend_valid_reg <= 1'b0;
            nfire_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            wr_reg         <= wr_next;
            id_ctr_reg     <= id_ctr_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            nfire_reg      <= nfire_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        resp_id_reg     <= resp_id_next;
        resp_status_reg <= resp_status_next;
        pend_id_reg     <= pend_id_next;
        rsp_data_reg    <= rsp_data_next;
    end

    // fill count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOTS_CNT)
        else $error("fill count beyond table size");

    // compaction write slot stays at or behind the entry being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_SCAN) |-> (wr_reg <= idx_reg))
        else $error("compaction write slot ahead of read slot");

    // a successful add advances the id counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && used_reg != SLOTS_CNT)
        |=> (id_ctr_reg == $past(id_ctr_reg) + 32'd1))
        else $error("id counter not advanced on add");

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !emit)
        else $error("result overwritten while stalled");

endmodule

// File: src/ott_ram.sv
module ott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
